[rtl/spq_pkg.sv]
`default_nettype none

package spq_pkg;

  // queue geometry
  localparam int QDEPTH = 64;
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  // append stores 1.0 as the fine key (Q8.8)
  localparam logic [15:0] FINE_ONE = 16'd256;

  typedef logic [CNT_W-1:0] cnt_t;

  // one stored entry
  typedef struct packed {
    logic [31:0] level;
    logic [15:0] fine;
    logic [31:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // per-cell compare results against the accepted beat
  typedef struct packed {
    logic ge;
    logic match;
  } cell_flag_t;

  // per-cell update command
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_LEFT,
    CMD_RIGHT
  } cell_cmd_t;

  // operation codes
  typedef enum logic [2:0] {
    MODE_INSERT   = 3'd0,
    MODE_APPEND   = 3'd1,
    MODE_POP_HEAD = 3'd2,
    MODE_POP_TAIL = 3'd3,
    MODE_REMOVE   = 3'd4,
    MODE_CLEAR    = 3'd5
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_t;

  // control sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_t;

endpackage

`default_nettype wire

[rtl/stable_two_key_priority_queue_core.sv]
// Flow: an accepted operation beat has its key compared in every cell, then a commit step
// in which the whole chain inserts, shifts or removes in parallel and the result is registered;
// the commit waits while out_ready stalls a result; no new beat is accepted before it commits.
// Reset: synchronous active-low rst_n empties the queue and clears the handshake state;
// the cell entries themselves are not cleared and are only read below the fill count.
`default_nettype none

module stable_two_key_priority_queue_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  in_mode,
  input  wire  [31:0] in_key_level,
  input  wire  [15:0] in_key_fine,
  input  wire  [31:0] in_payload,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_payload,
  output logic [31:0] out_level,
  output logic [15:0] out_fine,
  output logic [1:0]  out_status,
  output logic [6:0]  out_entry_count
);

  spq_pkg::entry_t     q     [spq_pkg::QDEPTH];
  spq_pkg::cell_flag_t flags [spq_pkg::QDEPTH];
  spq_pkg::cell_cmd_t  cmd   [spq_pkg::QDEPTH];
  spq_pkg::entry_t     new_entry;
  spq_pkg::entry_t     sel_data;
  logic [spq_pkg::ENTRY_W-1:0] sel_bits;
  logic [spq_pkg::QDEPTH-1:0]  sel;
  logic [spq_pkg::QDEPTH-1:0]  col;
  logic                        flag_load;

  spq_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_key_level    (in_key_level),
    .in_key_fine     (in_key_fine),
    .in_payload      (in_payload),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_payload     (out_payload),
    .out_level       (out_level),
    .out_fine        (out_fine),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .flags           (flags),
    .sel_data        (sel_data),
    .flag_load       (flag_load),
    .cmd             (cmd),
    .new_entry       (new_entry),
    .sel             (sel)
  );

  // chain of cells, head at cell 0
  for (genvar g = 0; g < spq_pkg::QDEPTH; g++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;

    if (g == 0) begin : g_head
      assign left_e = '0;
    end else begin : g_mid_l
      assign left_e = q[g-1];
    end

    if (g == spq_pkg::QDEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid_r
      assign right_e = q[g+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .flag_load   (flag_load),
      .key_level   (in_key_level),
      .key_fine    (in_key_fine),
      .key_tag     (in_payload),
      .cmd         (cmd[g]),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .q           (q[g]),
      .flag        (flags[g])
    );
  end

  // one-hot and-or read of the leaving entry
  always_comb begin
    for (int b = 0; b < spq_pkg::ENTRY_W; b++) begin
      for (int i = 0; i < spq_pkg::QDEPTH; i++) begin
        col[i] = q[i][b] & sel[i];
      end
      sel_bits[b] = |col;
    end
  end

  assign sel_data = spq_pkg::entry_t'(sel_bits);

endmodule

`default_nettype wire

[rtl/spq_cell.sv]
`default_nettype none

module spq_cell (
  input  wire                    clk,
  input  wire                    flag_load,
  input  wire  [31:0]            key_level,
  input  wire  [15:0]            key_fine,
  input  wire  [31:0]            key_tag,
  input  spq_pkg::cell_cmd_t     cmd,
  input  spq_pkg::entry_t        new_entry,
  input  spq_pkg::entry_t        left_entry,
  input  spq_pkg::entry_t        right_entry,
  output spq_pkg::entry_t        q,
  output spq_pkg::cell_flag_t    flag
);

  spq_pkg::entry_t     entry_r;
  spq_pkg::entry_t     entry_nxt;
  spq_pkg::cell_flag_t flag_r;
  spq_pkg::cell_flag_t flag_nxt;

  // key compare: new key not less than the held key, and tag match
  always_comb begin
    flag_nxt.ge    = {key_level, key_fine} >= {entry_r.level, entry_r.fine};
    flag_nxt.match = (key_tag == entry_r.tag);
  end

  // entry update from the command
  always_comb begin
    case (cmd)
      spq_pkg::CMD_LOAD:  entry_nxt = new_entry;
      spq_pkg::CMD_LEFT:  entry_nxt = left_entry;
      spq_pkg::CMD_RIGHT: entry_nxt = right_entry;
      default:            entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (flag_load) begin
      flag_r <= flag_nxt;
    end
  end

  assign q    = entry_r;
  assign flag = flag_r;

endmodule

`default_nettype wire

[rtl/spq_ctrl.sv]
`default_nettype none

module spq_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [2:0]              in_mode,
  input  wire  [31:0]             in_key_level,
  input  wire  [15:0]             in_key_fine,
  input  wire  [31:0]             in_payload,
  input  wire                     out_ready,
  output logic                    out_valid,
  output logic [31:0]             out_payload,
  output logic [31:0]             out_level,
  output logic [15:0]             out_fine,
  output logic [1:0]              out_status,
  output logic [6:0]              out_entry_count,
  input  spq_pkg::cell_flag_t     flags [spq_pkg::QDEPTH],
  input  spq_pkg::entry_t         sel_data,
  output logic                    flag_load,
  output spq_pkg::cell_cmd_t      cmd [spq_pkg::QDEPTH],
  output spq_pkg::entry_t         new_entry,
  output logic [spq_pkg::QDEPTH-1:0] sel
);

  spq_pkg::fsm_t    state_r;
  spq_pkg::fsm_t    state_nxt;
  logic             go;
  logic [2:0]       mode_r;
  spq_pkg::entry_t  new_r;
  spq_pkg::cnt_t    count_r;
  spq_pkg::cnt_t    cnt_nxt;
  spq_pkg::cnt_t    cnt_m1;
  spq_pkg::status_t st;
  logic             full;
  logic             empty;

  logic [spq_pkg::QDEPTH-1:0] vld;
  logic [spq_pkg::QDEPTH-1:0] ge_v;
  logic [spq_pkg::QDEPTH-1:0] m_v;
  logic [spq_pkg::QDEPTH-1:0] after;
  logic [spq_pkg::QDEPTH-1:0] after_prev;
  logic [spq_pkg::QDEPTH-1:0] pre;
  logic [spq_pkg::QDEPTH-1:0] pre_prev;
  logic [spq_pkg::CNT_W+6:0]  cnt_ext;

  logic             out_valid_r;
  logic [31:0]      out_payload_r;
  logic [31:0]      out_level_r;
  logic [15:0]      out_fine_r;
  spq_pkg::status_t out_status_r;
  logic [6:0]       out_entry_count_r;

  // sequencer: accept in idle, commit once the output register is free
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    go        = 1'b0;
    unique case (state_r)
      spq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        if (!out_valid_r || out_ready) begin
          go        = 1'b1;
          state_nxt = spq_pkg::S_IDLE;
        end
      end
      default: state_nxt = spq_pkg::S_IDLE;
    endcase
  end

  assign flag_load = in_valid && in_ready;
  assign new_entry = new_r;

  // occupancy mask and masked flag vectors
  always_comb begin
    for (int i = 0; i < spq_pkg::QDEPTH; i++) begin
      vld[i]  = spq_pkg::cnt_t'(i) < count_r;
      ge_v[i] = flags[i].ge & vld[i];
      m_v[i]  = flags[i].match & vld[i];
    end
    // after: some entry at or behind this place is not greater than the key
    // pre: some entry at or ahead of this place matches the tag
    for (int i = 0; i < spq_pkg::QDEPTH; i++) begin
      after[i] = |(ge_v >> i);
      pre[i]   = |(m_v << (spq_pkg::QDEPTH - 1 - i));
    end
    after_prev = {after[spq_pkg::QDEPTH-2:0], 1'b1};
    pre_prev   = {pre[spq_pkg::QDEPTH-2:0], 1'b0};
  end

  assign full   = (count_r >= spq_pkg::cnt_t'(spq_pkg::QDEPTH));
  assign empty  = (count_r == '0);
  assign cnt_m1 = count_r - spq_pkg::cnt_t'(1);

  // per-cell commands, selection and status
  always_comb begin
    for (int i = 0; i < spq_pkg::QDEPTH; i++) begin
      cmd[i] = spq_pkg::CMD_HOLD;
    end
    sel     = '0;
    st      = spq_pkg::ST_OK;
    cnt_nxt = count_r;
    if (go) begin
      case (mode_r)
        spq_pkg::MODE_INSERT: begin
          if (full) begin
            st = spq_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < spq_pkg::QDEPTH; i++) begin
              if (after[i]) begin
                cmd[i] = spq_pkg::CMD_HOLD;
              end else if (after_prev[i]) begin
                cmd[i] = spq_pkg::CMD_LOAD;
              end else begin
                cmd[i] = spq_pkg::CMD_LEFT;
              end
            end
            cnt_nxt = count_r + spq_pkg::cnt_t'(1);
          end
        end
        spq_pkg::MODE_APPEND: begin
          if (full) begin
            st = spq_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < spq_pkg::QDEPTH; i++) begin
              if (spq_pkg::cnt_t'(i) == count_r) begin
                cmd[i] = spq_pkg::CMD_LOAD;
              end
            end
            cnt_nxt = count_r + spq_pkg::cnt_t'(1);
          end
        end
        spq_pkg::MODE_POP_HEAD: begin
          if (empty) begin
            st = spq_pkg::ST_EMPTY;
          end else begin
            for (int i = 0; i < spq_pkg::QDEPTH; i++) begin
              cmd[i] = spq_pkg::CMD_RIGHT;
            end
            sel[0]  = 1'b1;
            cnt_nxt = cnt_m1;
          end
        end
        spq_pkg::MODE_POP_TAIL: begin
          if (empty) begin
            st = spq_pkg::ST_EMPTY;
          end else begin
            for (int i = 0; i < spq_pkg::QDEPTH; i++) begin
              sel[i] = (spq_pkg::cnt_t'(i) == cnt_m1);
            end
            cnt_nxt = cnt_m1;
          end
        end
        spq_pkg::MODE_REMOVE: begin
          if (empty) begin
            st = spq_pkg::ST_EMPTY;
          end else if (!(|m_v)) begin
            st = spq_pkg::ST_NO_MATCH;
          end else begin
            for (int i = 0; i < spq_pkg::QDEPTH; i++) begin
              sel[i] = pre[i] & ~pre_prev[i];
              if (pre[i]) begin
                cmd[i] = spq_pkg::CMD_RIGHT;
              end
            end
            cnt_nxt = cnt_m1;
          end
        end
        spq_pkg::MODE_CLEAR: begin
          cnt_nxt = '0;
        end
        default: begin
          cnt_nxt = count_r;
        end
      endcase
    end
  end

  assign cnt_ext = {7'd0, cnt_nxt};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= cnt_nxt;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // operand capture and result register
  always_ff @(posedge clk) begin
    if (flag_load) begin
      mode_r        <= in_mode;
      new_r.level   <= in_key_level;
      new_r.tag     <= in_payload;
      new_r.fine    <= (in_mode == spq_pkg::MODE_APPEND) ? spq_pkg::FINE_ONE : in_key_fine;
    end
    if (go) begin
      out_payload_r     <= sel_data.tag;
      out_level_r       <= sel_data.level;
      out_fine_r        <= sel_data.fine;
      out_status_r      <= st;
      out_entry_count_r <= cnt_ext[6:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_payload     = out_payload_r;
  assign out_level       = out_level_r;
  assign out_fine        = out_fine_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;

endmodule

`default_nettype wire

[rtl/spq_checker.sv]
`default_nettype none

module spq_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_payload,
  input wire [31:0] out_level,
  input wire [15:0] out_fine,
  input wire [1:0]  out_status,
  input wire [6:0]  out_entry_count
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload) && $stable(out_level)
      && $stable(out_fine) && $stable(out_status) && $stable(out_entry_count))
    else $error("result beat changed while stalled");

  // one operation in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted during operation");

  // a failed operation carries no entry
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != 2'(spq_pkg::ST_OK))
      |-> (out_payload == '0) && (out_level == '0) && (out_fine == '0))
    else $error("error result carries entry data");

  // occupancy stays within the queue depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_entry_count} <= 8'(spq_pkg::QDEPTH)))
    else $error("entry count beyond depth");

  // reset drops any pending result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stable_two_key_priority_queue_core spq_checker u_spq_checker (.*);

`default_nettype wire
